// File: sv/bat_pkg.sv
// Shared types and constants for the advertising device table.
// Holds the request and response words, entry layout and control codes.
// No dependencies; imported by ble_adv_device_table, the checker and the testbench.
package bat_pkg;

  localparam int DEF_TABLE_ENTRIES    = 32;
  localparam int DEF_NAME_FIELD_BYTES = 28;
  localparam int DEF_ADV_MAX_BYTES    = 31;

  // AD structure types that carry a local name
  localparam logic [7:0] TYPE_SHORT_NAME = 8'h08;
  localparam logic [7:0] TYPE_FULL_NAME  = 8'h09;

  // Widest stored name length (NAME_FIELD_BYTES - 1 stays below 64)
  localparam int NLEN_W = 6;

  typedef enum logic [1:0] {
    REQ_ADV   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    OUT_UPDATED  = 2'd0,
    OUT_INSERTED = 2'd1,
    OUT_DROPPED  = 2'd2,
    OUT_NO_ENTRY = 2'd3
  } outcome_t;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_COPY = 2'd2,
    PH_IDLE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_READ,
    S_WALK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [47:0]       sender_address;
    logic [7:0]        sender_address_type;
    logic signed [7:0] signal_strength;
    logic [4:0]        report_length;
    logic [4:0]        byte_position;
    logic [7:0]        data_byte;
    logic              is_last;
    logic [4:0]        entry_index;
    logic [4:0]        name_offset;
  } req_t;

  typedef struct packed {
    logic              result_kind;
    logic [4:0]        slot;
    logic [1:0]        outcome;
    logic              named;
    logic [4:0]        name_length;
    logic [5:0]        entries_used;
    logic [47:0]       entry_address;
    logic [7:0]        entry_address_type;
    logic signed [7:0] entry_signal;
    logic [7:0]        name_byte;
  } rsp_t;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [47:0]       addr;
    logic [7:0]        atype;
    logic signed [7:0] sig;
    logic              named;
    logic [NLEN_W-1:0] nlen;
  } entry_t;

endpackage

// File: sv/ble_adv_device_table.sv
// Device table for BLE scan reports with local-name capture. One word is taken at a
// time. An advertising byte passes accept, decode and walk, plus a result step on the
// last byte. The first byte of a report also searches the entry memory, one entry
// per cycle, between decode and walk. A read passes accept, decode, read and result
// (the read step is skipped for a slot beyond the used entries); a clear passes accept
// and decode. The table needs no clearing pass after reset.
// A finished result waits in an output register while the next word is accepted.
// Depends on bat_pkg and bat_ram.
module ble_adv_device_table
  import bat_pkg::*;
#(
  parameter int TABLE_ENTRIES    = DEF_TABLE_ENTRIES,
  parameter int NAME_FIELD_BYTES = DEF_NAME_FIELD_BYTES,
  parameter int ADV_MAX_BYTES    = DEF_ADV_MAX_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int NS   = NAME_FIELD_BYTES - 1;
  localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int NDEP = TABLE_ENTRIES * NS;
  localparam int NAW  = (NDEP > 1) ? $clog2(NDEP) : 1;
  localparam int CPW  = $clog2(NS + 1);

  state_t          state, state_next;
  req_t            cur, cur_next;
  logic [CW-1:0]   used_count, used_count_next;
  logic [IW-1:0]   active_slot, active_slot_next;
  logic [1:0]      report_status, report_status_next;
  phase_t          phase, phase_next;
  logic [8:0]      nss, nss_next;
  logic [7:0]      struct_length, struct_length_next;
  logic [CPW-1:0]  copied, copied_next;
  entry_t          act, act_next;
  logic [CW-1:0]   ptr, ptr_next;
  logic            cmp_pend, cmp_pend_next;
  logic [IW-1:0]   cmp_idx, cmp_idx_next;
  rsp_t            pend, pend_next;
  rsp_t            rsp_next;
  logic            rsp_valid_next;

  logic            ent_we;
  logic [IW-1:0]   ent_waddr, ent_raddr;
  entry_t          ent_wdata, ent_rdata;
  logic            name_we;
  logic [NAW-1:0]  name_waddr, name_raddr;
  logic [7:0]      name_wdata, name_rdata;

  logic            search_hit, search_end, read_ok, load_ok;
  logic [4:0]      len;
  logic [9:0]      nl_raw;
  logic [NLEN_W-1:0] nl;

  bat_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  bat_ram #(.WIDTH(8), .DEPTH(NDEP)) u_name_ram (
    .clk(clk), .we(name_we), .waddr(name_waddr), .wdata(name_wdata),
    .raddr(name_raddr), .rdata(name_rdata)
  );

  // decode helpers
  assign len = (int'(cur.report_length) > ADV_MAX_BYTES) ?
               5'(ADV_MAX_BYTES) : cur.report_length;
  assign search_hit = cmp_pend && (ent_rdata.addr == cur.sender_address);
  assign search_end = !cmp_pend && (ptr >= used_count);
  assign read_ok    = int'(cur.entry_index) < int'(used_count);
  assign load_ok    = !rsp_valid || !rsp_stall;
  assign nl_raw     = 10'(struct_length) - 10'd1;
  assign nl         = (int'(nl_raw) > NS) ? NLEN_W'(NS) : NLEN_W'(nl_raw);
  assign req_stall  = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (cur.req_type)
          REQ_READ: state_next = read_ok ? S_READ : S_RESULT;
          REQ_ADV:  state_next = (cur.byte_position == 5'd0) ? S_SEARCH : S_WALK;
          default:  state_next = S_IDLE;
        endcase
      end
      S_SEARCH: if (search_hit || search_end) state_next = S_WALK;
      S_READ:   state_next = S_RESULT;
      S_WALK:   state_next = cur.is_last ? S_RESULT : S_IDLE;
      S_RESULT: if (load_ok) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cur_next           = cur;
    used_count_next    = used_count;
    active_slot_next   = active_slot;
    report_status_next = report_status;
    phase_next         = phase;
    nss_next           = nss;
    struct_length_next = struct_length;
    copied_next        = copied;
    act_next           = act;
    ptr_next           = ptr;
    cmp_pend_next      = cmp_pend;
    cmp_idx_next       = cmp_idx;
    pend_next          = pend;
    rsp_next           = rsp;
    rsp_valid_next     = rsp_valid && rsp_stall;
    ent_we             = 1'b0;
    ent_waddr          = active_slot;
    ent_wdata          = act;
    ent_raddr          = ptr[IW-1:0];
    name_we            = 1'b0;
    name_waddr         = NAW'(active_slot) * NAW'(NS) + NAW'(copied);
    name_wdata         = cur.data_byte;
    name_raddr         = NAW'(cur.entry_index) * NAW'(NS) +
                         ((int'(cur.name_offset) < NS) ? NAW'(cur.name_offset) : '0);
    case (state)
      S_IDLE: begin
        if (req_valid) cur_next = req;
      end

      S_DECODE: begin
        ent_raddr = IW'(cur.entry_index);
        case (cur.req_type)
          REQ_CLEAR: begin
            used_count_next = '0;
            phase_next      = PH_IDLE;
          end
          REQ_READ: begin
            pend_next              = '0;
            pend_next.result_kind  = KIND_READ;
            pend_next.slot         = cur.entry_index;
            pend_next.outcome      = OUT_NO_ENTRY;
            pend_next.entries_used = 6'(used_count);
          end
          REQ_ADV: begin
            if (cur.byte_position == 5'd0) begin
              ptr_next           = '0;
              cmp_pend_next      = 1'b0;
              nss_next           = '0;
              struct_length_next = '0;
              copied_next        = '0;
            end
          end
          default: ;
        endcase
      end

      // pipelined address search: issue one read, compare the previous
      S_SEARCH: begin
        if (search_hit) begin
          act_next           = ent_rdata;
          act_next.sig       = cur.signal_strength;
          active_slot_next   = cmp_idx;
          report_status_next = OUT_UPDATED;
          phase_next         = ent_rdata.named ? PH_IDLE : PH_LEN;
          cmp_pend_next      = 1'b0;
          ent_we             = 1'b1;
          ent_waddr          = cmp_idx;
          ent_wdata          = act_next;
        end else if (ptr < used_count) begin
          ptr_next      = ptr + CW'(1);
          cmp_pend_next = 1'b1;
          cmp_idx_next  = ptr[IW-1:0];
        end else if (cmp_pend) begin
          cmp_pend_next = 1'b0;
        end else if (int'(used_count) < TABLE_ENTRIES) begin
          act_next.addr      = cur.sender_address;
          act_next.atype     = cur.sender_address_type;
          act_next.sig       = cur.signal_strength;
          act_next.named     = 1'b0;
          act_next.nlen      = '0;
          active_slot_next   = used_count[IW-1:0];
          report_status_next = OUT_INSERTED;
          used_count_next    = used_count + CW'(1);
          phase_next         = PH_LEN;
          ent_we             = 1'b1;
          ent_waddr          = used_count[IW-1:0];
          ent_wdata          = act_next;
        end else begin
          active_slot_next   = '0;
          report_status_next = OUT_DROPPED;
          phase_next         = PH_IDLE;
        end
      end

      S_READ: begin
        pend_next                    = '0;
        pend_next.result_kind        = KIND_READ;
        pend_next.slot               = cur.entry_index;
        pend_next.outcome            = OUT_UPDATED;
        pend_next.named              = ent_rdata.named;
        pend_next.name_length        = ent_rdata.named ? 5'(ent_rdata.nlen) : 5'd0;
        pend_next.entries_used       = 6'(used_count);
        pend_next.entry_address      = ent_rdata.addr;
        pend_next.entry_address_type = ent_rdata.atype;
        pend_next.entry_signal       = ent_rdata.sig;
        if (ent_rdata.named && int'(cur.name_offset) < int'(ent_rdata.nlen) &&
            int'(cur.name_offset) < NS) begin
          pend_next.name_byte = name_rdata;
        end
      end

      // walk the AD structures one byte at a time
      S_WALK: begin
        if (cur.byte_position < len && int'(active_slot) < int'(used_count)) begin
          case (phase)
            PH_LEN: begin
              if (9'(cur.byte_position) == nss) begin
                if (cur.data_byte == 8'd0 ||
                    9'(cur.byte_position) + 9'(cur.data_byte) >= 9'(len)) begin
                  phase_next = PH_IDLE;
                end else begin
                  struct_length_next = cur.data_byte;
                  phase_next         = PH_TYPE;
                end
              end
            end
            PH_TYPE: begin
              if (10'(cur.byte_position) == 10'(nss) + 10'd1) begin
                if (cur.data_byte == TYPE_SHORT_NAME || cur.data_byte == TYPE_FULL_NAME) begin
                  act_next.named = 1'b1;
                  act_next.nlen  = nl;
                  copied_next    = '0;
                  phase_next     = (nl == '0) ? PH_IDLE : PH_COPY;
                  ent_we         = 1'b1;
                  ent_wdata      = act_next;
                end else begin
                  nss_next   = nss + 9'(struct_length) + 9'd1;
                  phase_next = PH_LEN;
                end
              end
            end
            PH_COPY: begin
              if (10'(cur.byte_position) == 10'(nss) + 10'd2 + 10'(copied)) begin
                name_we     = 1'b1;
                copied_next = copied + CPW'(1);
                if (int'(copied) + 1 >= int'(act.nlen)) phase_next = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        if (cur.is_last) begin
          phase_next             = PH_IDLE;
          pend_next              = '0;
          pend_next.result_kind  = KIND_REPORT;
          pend_next.outcome      = report_status;
          pend_next.entries_used = 6'(used_count);
          if (report_status != OUT_DROPPED && int'(active_slot) < int'(used_count)) begin
            pend_next.slot        = 5'(active_slot);
            pend_next.named       = act_next.named;
            pend_next.name_length = act_next.named ? 5'(act_next.nlen) : 5'd0;
          end
        end
      end

      // hand the result word to the output register
      S_RESULT: begin
        if (load_ok) begin
          rsp_next       = pend;
          rsp_valid_next = 1'b1;
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used_count    <= '0;
      active_slot   <= '0;
      report_status <= '0;
      phase         <= PH_LEN;
      nss           <= '0;
      struct_length <= '0;
      copied        <= '0;
      ptr           <= '0;
      cmp_pend      <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      used_count    <= used_count_next;
      active_slot   <= active_slot_next;
      report_status <= report_status_next;
      phase         <= phase_next;
      nss           <= nss_next;
      struct_length <= struct_length_next;
      copied        <= copied_next;
      ptr           <= ptr_next;
      cmp_pend      <= cmp_pend_next;
      rsp_valid     <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    act     <= act_next;
    cmp_idx <= cmp_idx_next;
    pend    <= pend_next;
    rsp     <= rsp_next;
  end

endmodule

// File: sv/bat_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module bat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/adv_table_checker.sv
// Checker for the advertising device table: watches both channels, predicts each
// result from its own copy of the table and compares field by field.
// Depends on bat_pkg.
`timescale 1ns / 1ps
module adv_table_checker
  import bat_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  localparam int NSTORE = DEF_NAME_FIELD_BYTES - 1;

  // mirrored table and walk state
  int unsigned   used;
  logic [47:0]   t_addr [DEF_TABLE_ENTRIES];
  logic [7:0]    t_atype [DEF_TABLE_ENTRIES];
  logic [7:0]    t_sig [DEF_TABLE_ENTRIES];
  logic          t_named [DEF_TABLE_ENTRIES];
  int unsigned   t_nlen [DEF_TABLE_ENTRIES];
  logic [7:0]    t_name [DEF_TABLE_ENTRIES][NSTORE];
  int unsigned   cur_slot, status, next_start, slen, copied;
  phase_t        phase;
  rsp_t          expected_rsps [$];

  assign pending = expected_rsps.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  // look the sender up, then insert or drop
  task automatic open_report(input req_t w);
    int unsigned i;
    next_start = 0; slen = 0; copied = 0;
    for (i = 0; i < used; i++) begin
      if (t_addr[i] == w.sender_address) begin
        cur_slot = i; status = OUT_UPDATED; t_sig[i] = w.signal_strength;
        phase = t_named[i] ? PH_IDLE : PH_LEN;
        return;
      end
    end
    if (used < DEF_TABLE_ENTRIES) begin
      cur_slot = used; status = OUT_INSERTED;
      t_addr[used] = w.sender_address; t_atype[used] = w.sender_address_type;
      t_sig[used] = w.signal_strength; t_named[used] = 0; t_nlen[used] = 0;
      used++; phase = PH_LEN;
    end else begin
      cur_slot = 0; status = OUT_DROPPED; phase = PH_IDLE;
    end
  endtask

  // advance the name search by one data word
  task automatic walk_name(input int unsigned pos, input int unsigned len,
                           input int unsigned b);
    int unsigned nl;
    if (pos >= len || cur_slot >= used) return;
    case (phase)
      PH_LEN: begin
        if (pos != next_start) return;
        if (b == 0 || pos + b >= len) phase = PH_IDLE;
        else begin slen = b; phase = PH_TYPE; end
      end
      PH_TYPE: begin
        if (pos != next_start + 1) return;
        if (b == TYPE_SHORT_NAME || b == TYPE_FULL_NAME) begin
          nl = slen - 1;
          if (nl > NSTORE) nl = NSTORE;
          t_nlen[cur_slot] = nl; t_named[cur_slot] = 1; copied = 0;
          phase = (nl == 0) ? PH_IDLE : PH_COPY;
        end else begin
          next_start += slen + 1; phase = PH_LEN;
        end
      end
      PH_COPY: begin
        if (pos != next_start + 2 + copied) return;
        if (copied < NSTORE) t_name[cur_slot][copied] = 8'(b);
        copied++;
        if (copied >= t_nlen[cur_slot]) phase = PH_IDLE;
      end
      default: ;
    endcase
  endtask

  task automatic predict_word(input req_t w);
    rsp_t r;
    int unsigned len;
    r = '0;
    case (req_kind_t'(w.req_type))
      REQ_CLEAR: begin used = 0; phase = PH_IDLE; end
      REQ_READ: begin
        r.result_kind = KIND_READ; r.slot = w.entry_index; r.entries_used = 6'(used);
        if (int'(w.entry_index) >= used) r.outcome = OUT_NO_ENTRY;
        else begin
          r.outcome = OUT_UPDATED;
          r.named = t_named[w.entry_index];
          r.name_length = t_named[w.entry_index] ? 5'(t_nlen[w.entry_index]) : 5'd0;
          r.entry_address = t_addr[w.entry_index];
          r.entry_address_type = t_atype[w.entry_index];
          r.entry_signal = t_sig[w.entry_index];
          if (t_named[w.entry_index] && int'(w.name_offset) < t_nlen[w.entry_index])
            r.name_byte = t_name[w.entry_index][w.name_offset];
        end
        expected_rsps.push_back(r);
      end
      REQ_ADV: begin
        len = int'(w.report_length);
        if (len > DEF_ADV_MAX_BYTES) len = DEF_ADV_MAX_BYTES;
        if (w.byte_position == 0) open_report(w);
        walk_name(int'(w.byte_position), len, int'(w.data_byte));
        if (w.is_last) begin
          r.result_kind = KIND_REPORT; r.outcome = 2'(status); r.entries_used = 6'(used);
          if (status != OUT_DROPPED && cur_slot < used) begin
            r.slot = 5'(cur_slot); r.named = t_named[cur_slot];
            r.name_length = t_named[cur_slot] ? 5'(t_nlen[cur_slot]) : 5'd0;
          end
          phase = PH_IDLE;
          expected_rsps.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      used = 0; cur_slot = 0; status = 0; phase = PH_LEN;
      next_start = 0; slen = 0; copied = 0;
      fail_count = 0; results_seen = 0;
      expected_rsps.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (expected_rsps.size() == 0)
          report_mismatch("unexpected result", 64'(rsp.slot), 64'd0);
        else begin
          want = expected_rsps.pop_front();
          if (rsp.result_kind !== want.result_kind)
            report_mismatch("result_kind", 64'(rsp.result_kind), 64'(want.result_kind));
          if (rsp.slot !== want.slot)
            report_mismatch("slot", 64'(rsp.slot), 64'(want.slot));
          if (rsp.outcome !== want.outcome)
            report_mismatch("outcome", 64'(rsp.outcome), 64'(want.outcome));
          if (rsp.named !== want.named)
            report_mismatch("named", 64'(rsp.named), 64'(want.named));
          if (rsp.name_length !== want.name_length)
            report_mismatch("name_length", 64'(rsp.name_length), 64'(want.name_length));
          if (rsp.entries_used !== want.entries_used)
            report_mismatch("entries_used", 64'(rsp.entries_used),
                            64'(want.entries_used));
          if (rsp.entry_address !== want.entry_address)
            report_mismatch("entry_address", 64'(rsp.entry_address),
                            64'(want.entry_address));
          if (rsp.entry_address_type !== want.entry_address_type)
            report_mismatch("entry_address_type", 64'(rsp.entry_address_type),
                            64'(want.entry_address_type));
          if (rsp.entry_signal !== want.entry_signal)
            report_mismatch("entry_signal", 64'(unsigned'(rsp.entry_signal)),
                            64'(unsigned'(want.entry_signal)));
          if (rsp.name_byte !== want.name_byte)
            report_mismatch("name_byte", 64'(rsp.name_byte), 64'(want.name_byte));
        end
      end
      if (req_valid && !req_stall) predict_word(req);
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the device table testbench: clock, reset, scan report stimulus and verdict.
// Drives ble_adv_device_table and checks it through adv_table_checker.
// Depends on bat_pkg and the block's sources.
`timescale 1ns / 1ps
module testbench;
  import bat_pkg::*;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  req_t req;
  rsp_t rsp;
  int   fail_count, pending, results_seen;
  int   words_sent, reports_sent, reads_sent;
  bit   hold_off;
  logic [47:0] known_addrs [$];

  ble_adv_device_table dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  adv_table_checker checker_i (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int unsigned mode;
    rsp_stall <= 0;
    forever begin
      @(posedge clk);
      if (hold_off) rsp_stall <= 1;
      else begin
        mode = (words_sent / 300) % 3;
        if (mode == 0) rsp_stall <= 0;
        else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
        else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  // hand one word over and wait for it to be taken, with bursty gaps
  task automatic send_word(input req_t w);
    int unsigned gap;
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req <= w;
    req_valid <= 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_sent++;
  endtask

  function automatic req_t blank_word(input req_kind_t k);
    req_t w;
    w = '0;
    w.req_type = k;
    return w;
  endfunction

  // random filler for a whole request word
  function automatic req_t random_word();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(req_t)-1:0];
  endfunction

  // pick a sender: reuse a known one one time in three so updates happen
  function automatic logic [47:0] pick_addr();
    logic [63:0] raw;
    if (known_addrs.size() > 0 && $urandom_range(0, 2) == 0)
      return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    raw = {$urandom(), $urandom()};
    return raw[47:0];
  endfunction

  // stream one scan report; bytes may be given explicitly or made up
  task automatic send_report(input logic [47:0] a, input logic [7:0] data [],
                             input bit shuffle);
    req_t w;
    int unsigned n, i;
    n = data.size();
    w = blank_word(REQ_ADV);
    w.sender_address = a;
    w.sender_address_type = 8'($urandom());
    w.signal_strength = 8'($urandom());
    w.report_length = 5'(n);
    w.entry_index = 5'($urandom());
    w.name_offset = 5'($urandom());
    if (known_addrs.size() < 64) known_addrs.push_back(a);
    if (n == 0) begin
      w.byte_position = 5'd0;
      w.data_byte = 8'($urandom());
      w.is_last = 1'b1;
      send_word(w);
    end else begin
      for (i = 0; i < n; i++) begin
        w.byte_position = 5'(i);
        if (shuffle && i != 0 && $urandom_range(0, 4) == 0)
          w.byte_position = 5'($urandom_range(1, 30));
        w.data_byte = data[i];
        w.is_last = (i == n - 1);
        send_word(w);
      end
    end
    reports_sent++;
  endtask

  // mostly well-formed advertising data, a name type in some structures, random content
  function automatic void build_adv(ref logic [7:0] d [], input int unsigned total);
    int unsigned p, l;
    d = new[total];
    foreach (d[k]) d[k] = 8'($urandom());
    p = 0;
    while (p + 1 < total) begin
      l = $urandom_range(1, total - p - 1);
      if ($urandom_range(0, 9) == 0) l = total - p;
      d[p] = 8'(l);
      if (p + 1 < total)
        case ($urandom_range(0, 3))
          0: d[p + 1] = TYPE_SHORT_NAME;
          1: d[p + 1] = TYPE_FULL_NAME;
          2: d[p + 1] = 8'h01;
          default: ;
        endcase
      p += l + 1;
    end
  endfunction

  task automatic send_read(input int unsigned idx, input int unsigned off);
    req_t w;
    logic [63:0] raw;
    w = blank_word(REQ_READ);
    w.entry_index = 5'(idx);
    w.name_offset = 5'(off);
    raw = {$urandom(), $urandom()};
    w.sender_address = raw[47:0];
    w.data_byte = 8'($urandom());
    send_word(w);
    reads_sent++;
  endtask

  task automatic send_clear();
    req_t w;
    w = random_word();
    w.req_type = REQ_CLEAR;
    send_word(w);
    known_addrs.delete();
  endtask

  initial begin
    logic [7:0] d [];
    int unsigned i, k;
    req_t w;
    rst <= 1;
    req_valid <= 0;
    req <= '0;
    hold_off = 0;
    words_sent = 0; reports_sent = 0; reads_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty report, extreme names, malformed, empty name, reads
    d = new[0];
    send_report(48'hFFFF_FFFF_FFFF, d, 0);
    d = '{8'd30, TYPE_FULL_NAME, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
          8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52,
          8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a, 8'hff, 8'h00, 8'h80};
    d[0] = 8'd29;
    send_report(48'h0, d, 0);
    d = '{8'd0, TYPE_SHORT_NAME, 8'h61};
    send_report(48'h1, d, 0);
    d = '{8'd1, TYPE_SHORT_NAME, 8'd3, 8'h09, 8'h61, 8'h62};
    send_report(48'h2, d, 0);
    d = '{8'd2, 8'h01, 8'h06, 8'd5, TYPE_FULL_NAME, 8'h61};
    send_report(48'h3, d, 0);
    d = '{8'd2, TYPE_SHORT_NAME, 8'h7a};
    send_report(48'h1, d, 0);
    send_read(1, 0); send_read(1, 26); send_read(4, 0); send_read(31, 31);
    w = blank_word(REQ_NONE);
    send_word(w);
    w = blank_word(REQ_ADV);
    w.byte_position = 5'd5; w.report_length = 5'd31; w.data_byte = 8'hff; w.is_last = 1'b1;
    send_word(w);

    // fill the table, possibly past full, then read every slot
    for (i = 0; i < 36; i++) begin
      build_adv(d, $urandom_range(3, 8));
      send_report(pick_addr(), d, 0);
    end
    for (i = 0; i < 32; i++) send_read(i, $urandom_range(0, 26));

    // long receiver hold-off while reads keep coming
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (k = 0; k < 12; k++) send_read($urandom_range(0, 31), $urandom_range(0, 26));
    join
    send_clear();

    // random: mostly well-formed reports with random content, some noise
    while (words_sent < 1650) begin
      case ($urandom_range(0, 19))
        0: send_clear();
        1, 2, 3: send_read($urandom_range(0, 31), $urandom_range(0, 31));
        4: begin
          w = random_word();
          if (w.req_type == REQ_READ || w.req_type == REQ_CLEAR) w.req_type = REQ_NONE;
          if (w.req_type == REQ_ADV && w.byte_position == 0) w.byte_position = 5'd1;
          send_word(w);
        end
        5: begin
          d = new[$urandom_range(0, 31)];
          foreach (d[j]) d[j] = 8'($urandom());
          send_report(pick_addr(), d, 1);
        end
        default: begin
          build_adv(d, $urandom_range(2, 31));
          send_report(pick_addr(), d, ($urandom_range(0, 7) == 0));
        end
      endcase
    end
    req_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d words: %0d reports and %0d reads, %0d results checked.",
             words_sent, reports_sent, reads_sent, results_seen);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
